// ----- hw/rtl/kss_pkg.sv -----
// Package for the shared-store stack block: sizes, field widths, codes and the
// command and status bundles between the controller and the datapath.
// Depends on nothing.
`timescale 1ns / 1ps

package kss_pkg;

  // Block sizes.
  localparam int NumStacks = 4;
  localparam int Capacity  = 16;
  localparam int DataWidth = 32;

  // Field widths of the channels.
  localparam int OpW     = 1;
  localparam int SidW    = 2;
  localparam int ValW    = 32;
  localparam int StatusW = 2;

  // Slot index: Capacity itself codes the null link, so one more value is needed.
  localparam int IdxW  = $clog2(Capacity + 1);
  localparam int SlotW = $clog2(Capacity);
  localparam logic [IdxW-1:0] NullIdx = IdxW'(Capacity);

  // Operation codes.
  localparam logic [OpW-1:0] OpPush = 1'b0;
  localparam logic [OpW-1:0] OpPop  = 1'b1;

  // Result status codes.
  localparam logic [StatusW-1:0] StatusOk        = 2'd0;
  localparam logic [StatusW-1:0] StatusOverflow  = 2'd1;
  localparam logic [StatusW-1:0] StatusUnderflow = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // Input transfer: latch the item and read the stores.
    logic commit;   // Apply the item to the stores and load the result.
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free; // The output register can take a result this cycle.
  } sts_t;

endpackage

// ----- hw/rtl/kss_stream_if.sv -----
// Channel interfaces of the shared-store stack block: the item input and
// the result output, each with valid, ready and payload. Depends on kss_pkg.
`timescale 1ns / 1ps

interface kss_in_if;
  logic                        valid;
  logic                        ready;
  logic [kss_pkg::OpW-1:0]     operation;
  logic [kss_pkg::SidW-1:0]    stack_id;
  logic signed [kss_pkg::ValW-1:0] push_value;

  modport source (output valid, output operation, output stack_id, output push_value,
                  input ready);
  modport sink   (input valid, input operation, input stack_id, input push_value,
                  output ready);
endinterface

interface kss_out_if;
  logic                            valid;
  logic                            ready;
  logic [kss_pkg::StatusW-1:0]     status;
  logic signed [kss_pkg::ValW-1:0] popped_value;

  modport source (output valid, output status, output popped_value, input ready);
  modport sink   (input valid, input status, input popped_value, output ready);
endinterface

// ----- hw/rtl/kss_datapath.sv -----
// Datapath of the shared-store stack block: slot data and link stores, stack
// and free-list heads, and the result register. Depends on kss_pkg.
`timescale 1ns / 1ps

module kss_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  kss_pkg::cmd_t                   cmd_i,
  output kss_pkg::sts_t                   sts_o,
  input  logic [kss_pkg::OpW-1:0]         operation_i,
  input  logic [kss_pkg::SidW-1:0]        stack_id_i,
  input  logic signed [kss_pkg::ValW-1:0] push_value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [kss_pkg::StatusW-1:0]     status_o,
  output logic signed [kss_pkg::ValW-1:0] popped_value_o
);

  // Heads and link-store valid bits.
  logic [kss_pkg::IdxW-1:0]      head_q [kss_pkg::NumStacks];
  logic [kss_pkg::IdxW-1:0]      free_head_q;
  logic [kss_pkg::Capacity-1:0]  link_vld_q;

  // Stores.
  logic [kss_pkg::DataWidth-1:0] data_mem [kss_pkg::Capacity];
  logic [kss_pkg::IdxW-1:0]      link_mem [kss_pkg::Capacity];

  // Item latched at the input transfer.
  logic [kss_pkg::OpW-1:0]       op_q;
  logic [kss_pkg::SidW-1:0]      sid_q;
  logic [kss_pkg::DataWidth-1:0] val_q;
  logic [kss_pkg::IdxW-1:0]      slot_q;
  logic                          err_q;

  // Registered store reads.
  logic [kss_pkg::DataWidth-1:0] data_rd_q;
  logic [kss_pkg::IdxW-1:0]      link_rd_q;
  logic [kss_pkg::IdxW-1:0]      link_def_q;
  logic                          link_rd_vld_q;

  // Result register.
  logic                          out_valid_q;
  logic [kss_pkg::StatusW-1:0]   status_q;
  logic signed [kss_pkg::ValW-1:0] popped_q;

  logic                          sid_ok;
  logic                          is_push;
  logic [kss_pkg::IdxW-1:0]      rd_slot;
  logic                          rd_err;
  logic [kss_pkg::IdxW-1:0]      link_cur;
  logic [kss_pkg::IdxW-1:0]      link_wr;
  logic                          commit_ok;

  // Pick the slot the item works on: free-list head for a push, stack top for a pop.
  always_comb begin
    sid_ok  = int'(stack_id_i) < kss_pkg::NumStacks;
    is_push = (operation_i == kss_pkg::OpPush);
    if (is_push) begin
      rd_slot = free_head_q;
    end else if (sid_ok) begin
      rd_slot = head_q[stack_id_i];
    end else begin
      rd_slot = kss_pkg::NullIdx;
    end
    rd_err = (rd_slot == kss_pkg::NullIdx) || (is_push && !sid_ok);
  end

  // Latch the item and read both stores at the chosen slot.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q          <= operation_i;
      sid_q         <= stack_id_i;
      val_q         <= kss_pkg::DataWidth'(push_value_i);
      slot_q        <= rd_slot;
      err_q         <= rd_err;
      data_rd_q     <= data_mem[rd_slot[kss_pkg::SlotW-1:0]];
      link_rd_q     <= link_mem[rd_slot[kss_pkg::SlotW-1:0]];
      link_rd_vld_q <= link_vld_q[rd_slot[kss_pkg::SlotW-1:0]];
      link_def_q    <= rd_slot + kss_pkg::IdxW'(1);
    end
  end

  // A link entry never written still holds its reset value: the next slot.
  assign link_cur  = link_rd_vld_q ? link_rd_q : link_def_q;
  assign commit_ok = cmd_i.commit && !err_q;
  assign link_wr   = (op_q == kss_pkg::OpPush) ? head_q[sid_q] : free_head_q;

  // Store writes.
  always_ff @(posedge clk_i) begin
    if (commit_ok) begin
      link_mem[slot_q[kss_pkg::SlotW-1:0]] <= link_wr;
      if (op_q == kss_pkg::OpPush) begin
        data_mem[slot_q[kss_pkg::SlotW-1:0]] <= val_q;
      end
    end
  end

  // Head and valid-bit updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < kss_pkg::NumStacks; i++) begin
        head_q[i] <= kss_pkg::NullIdx;
      end
      free_head_q <= '0;
      link_vld_q  <= '0;
    end else if (commit_ok) begin
      link_vld_q[slot_q[kss_pkg::SlotW-1:0]] <= 1'b1;
      if (op_q == kss_pkg::OpPush) begin
        free_head_q   <= link_cur;
        head_q[sid_q] <= slot_q;
      end else begin
        head_q[sid_q] <= link_cur;
        free_head_q   <= slot_q;
      end
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload; a popped value is the slot data taken as signed, at the same width.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (!err_q) begin
        status_q <= kss_pkg::StatusOk;
        popped_q <= (op_q == kss_pkg::OpPush) ? '0 : kss_pkg::ValW'(signed'(data_rd_q));
      end else if (op_q == kss_pkg::OpPush) begin
        status_q <= kss_pkg::StatusOverflow;
        popped_q <= '0;
      end else begin
        status_q <= kss_pkg::StatusUnderflow;
        popped_q <= '1;
      end
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign popped_value_o = popped_q;

endmodule

// ----- hw/rtl/kss_ctrl.sv -----
// Controller of the shared-store stack block: a two-state sequencer that takes
// an item, then commits it once the result register is free. Depends on kss_pkg.
`timescale 1ns / 1ps

module kss_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  kss_pkg::sts_t sts_i,
  output kss_pkg::cmd_t cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic state_q;
  logic state_d;

  // Next state and commands.
  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = StExec;
        end
      end
      StExec: begin
        cmd_o.commit = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hw/rtl/k_stacks_shared_store.sv -----
// Four LIFO stacks share one store of 16 slots, with a linked free list handing
// slots out on push and taking them back on pop. Each item (push or pop) gives
// exactly one result: ok, overflow (push with no free slot) or underflow (pop of
// an empty stack, value -1); on an error nothing changes. The transfer reads the
// slot's data and link from the stores, whose read data is registered; once the
// result register is free, the item writes the stores and heads and loads the
// result register. A new item is taken once that result has moved into the
// result register, so a held result stalls the block only when a second result
// is ready behind it. No clearing pass is needed after reset.
`timescale 1ns / 1ps

module k_stacks_shared_store (
  input logic       clk_i,
  input logic       rst_ni,
  kss_in_if.sink    in_i,
  kss_out_if.source out_o
);

  kss_pkg::cmd_t cmd;
  kss_pkg::sts_t sts;

  // Sequencer.
  kss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Stores, heads and result register.
  kss_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .operation_i    (in_i.operation),
    .stack_id_i     (in_i.stack_id),
    .push_value_i   (in_i.push_value),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .status_o       (out_o.status),
    .popped_value_o (out_o.popped_value)
  );

endmodule
